// ===== src/seed_block_cipher_128_defines.svh =====
// assertion macros for the seed cipher block
`ifndef SEED_BLOCK_CIPHER_128_DEFINES_SVH
`define SEED_BLOCK_CIPHER_128_DEFINES_SVH
`ifndef SYNTHESIS
`define SEED_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("seed assertion failed");
`define SEED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("seed assertion failed");
`else
`define SEED_ASSERT_SAME(label, ante, cons)
`define SEED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/seed_pkg.sv =====
// types, constant tables and the g function of the seed cipher
package seed_pkg;

  localparam int ROUNDS = 16;
  localparam int CFG_AW = 4;
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [2047:0] SB1_TAB = {
    128'ha985d6d3541dac255d43181e51fcca63, 128'h2844209de0e2c817a58f037bbb13d2ee,
    128'h708c3fa832ddf674ec950b575c5bbd01, 128'h241c739810ccf2d92ce772839bd186c9,
    128'h6050a3eb0db69e4fb75ac678a612afd5, 128'h61c3b441527d8d081f9900190453f7e1,
    128'hfd762f27b08b0eaba26e934d697c090a, 128'hbfeff3c58714fe64de2e4b1a06216b66,
    128'h02f5928a0cb37ed07a4796e52680addf, 128'ha13037ae36152238f4a7454c81e98497,
    128'h35cbce3c7111c78975fbdaf8945982c4, 128'hff493967c0cfd7b80f8e4223916cdba4,
    128'h34f148c26f3d2d40be3ebcc1aaba4e55, 128'h3bdc687f9cd84a5677a0ed46b52b65fa,
    128'he3b9b19f5ef9e6b231ea6d5fe4f0cd88, 128'h163a58d462290733e81b0579906a2a9a
  };

  localparam logic [2047:0] SB2_TAB = {
    128'h38e82da6cfdeb3b8af6055c7446f6b5b, 128'hc36233b529a0e2a7d39111061cbc364b,
    128'hef886ca817c416f4c245e1d63f3d8e98, 128'h284ef63ea5f90ddfd82b667a272ff172,
    128'h42d441c07367ac8bf7ad801fca2caa34, 128'hd20beee95d9418f857ae08c513cd86b9,
    128'hff7dc131f58a6ab1d120d70222046871, 128'h07db9d9961bee659dd5190dc9aa3abd0,
    128'h810f471ae3ec8dbf967b5ca2a163234d, 128'hc89e9c3a0c2eba6e9f5af292f34978cc,
    128'h15fb70757f351003646dc674d5b4ea09, 128'h7619fe4012e0bd05fa01f02a5ea95643,
    128'h8514899bb0e5487997fc1e82218c1b5f, 128'h7754b21d254f0046ed5852eb7edac9fd,
    128'h3095653cb6e4bb7c0e50392632846993, 128'h37e724a4cb530a87d94c838fce3b4ab7
  };

  localparam logic [511:0] KC_TAB = {
    32'h9e3779b9, 32'h3c6ef373, 32'h78dde6e6, 32'hf1bbcdcc,
    32'he3779b99, 32'hc6ef3733, 32'h8dde6e67, 32'h1bbcdccf,
    32'h3779b99e, 32'h6ef3733c, 32'hdde6e678, 32'hbbcdccf1,
    32'h779b99e3, 32'hef3733c6, 32'hde6e678d, 32'hbcdccf1b
  };

  localparam logic [7:0] MSK0 = 8'hfc;
  localparam logic [7:0] MSK1 = 8'hf3;
  localparam logic [7:0] MSK2 = 8'hcf;
  localparam logic [7:0] MSK3 = 8'h3f;

  typedef logic [ROUNDS-1:0][63:0] seed_rk_tab_t;

  typedef struct packed {
    logic        vld;
    logic        dec;
    logic [63:0] l;
    logic [63:0] r;
  } seed_lane_t;

  typedef struct packed {
    seed_lane_t  lane;
    logic [31:0] c;
    logic [31:0] d;
  } seed_mid_t;

  typedef struct packed {
    logic        wr;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } seed_key_cmd_t;

  function automatic logic [7:0] sb1(input logic [7:0] x);
    return SB1_TAB[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] sb2(input logic [7:0] x);
    return SB2_TAB[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] kc(input logic [3:0] i);
    return KC_TAB[{~i, 5'b00000} +: 32];
  endfunction

  function automatic logic [31:0] seed_g(input logic [31:0] x);
    logic [7:0] y0, y1, y2, y3, z0, z1, z2, z3;
    y0 = sb1(x[7:0]);
    y1 = sb2(x[15:8]);
    y2 = sb1(x[23:16]);
    y3 = sb2(x[31:24]);
    z0 = (y0 & MSK0) ^ (y1 & MSK1) ^ (y2 & MSK2) ^ (y3 & MSK3);
    z1 = (y0 & MSK1) ^ (y1 & MSK2) ^ (y2 & MSK3) ^ (y3 & MSK0);
    z2 = (y0 & MSK2) ^ (y1 & MSK3) ^ (y2 & MSK0) ^ (y3 & MSK1);
    z3 = (y0 & MSK3) ^ (y1 & MSK0) ^ (y2 & MSK1) ^ (y3 & MSK2);
    return {z3, z2, z1, z0};
  endfunction

endpackage

// ===== src/seed_if.sv =====
// valid/ready channel interfaces for blocks and results
interface seed_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, req_type, block_high, block_low, input ready);
  modport sink (input valid, req_type, block_high, block_low, output ready);
endinterface

interface seed_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== src/seed_key_sched.sv =====
// round key derivation, one round key per cycle, and the round key table
module seed_key_sched (
  input  logic                   clk,
  input  logic                   rst_n,
  input  seed_pkg::seed_key_cmd_t cmd,
  output logic                   busy,
  output seed_pkg::seed_rk_tab_t rk
);
  import seed_pkg::*;

  typedef enum logic [1:0] {
    KS_IDLE = 2'b01,
    KS_RUN  = 2'b10
  } ks_state_t;

  ks_state_t    state_r, state_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  seed_rk_tab_t rk_r;
  logic [31:0]  hi, lo;

  always_comb begin
    hi = seed_g(a_r[63:32] + b_r[63:32] - kc(cnt_r));
    lo = seed_g(a_r[31:0] - b_r[31:0] + kc(cnt_r));
    state_nxt = state_r;
    a_nxt = a_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    case (state_r)
      KS_IDLE: begin
        state_nxt = KS_IDLE;
      end
      KS_RUN: begin
        if (cnt_r[0]) begin
          b_nxt = {b_r[55:0], b_r[63:56]};
        end else begin
          a_nxt = {a_r[7:0], a_r[63:8]};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(ROUNDS - 1)) begin
          state_nxt = KS_IDLE;
        end
      end
      default: begin
        state_nxt = KS_IDLE;
      end
    endcase
    if (cmd.wr) begin
      state_nxt = KS_RUN;
      a_nxt = cmd.key_high;
      b_nxt = cmd.key_low;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_RUN;
      a_r <= '0;
      b_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == KS_RUN) begin
      rk_r[cnt_r] <= {hi, lo};
    end
  end

  assign busy = (state_r == KS_RUN);
  assign rk = rk_r;

endmodule

// ===== src/seed_round.sv =====
// one feistel round as three register stages
module seed_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  seed_pkg::seed_lane_t lane_i,
  input  logic [63:0]         rk_enc,
  input  logic [63:0]         rk_dec,
  output seed_pkg::seed_lane_t lane_o
);
  import seed_pkg::*;

  seed_mid_t   s0_r, s0_nxt, s1_r, s1_nxt;
  seed_lane_t  s2_r, s2_nxt;
  logic [63:0] rk;
  logic [31:0] c0, c2, d2;

  always_comb begin
    rk = lane_i.dec ? rk_dec : rk_enc;
    c0 = lane_i.r[63:32] ^ rk[63:32];
    s0_nxt.lane = lane_i;
    s0_nxt.c = c0;
    s0_nxt.d = seed_g(lane_i.r[31:0] ^ rk[31:0] ^ c0);

    s1_nxt = s0_r;
    s1_nxt.c = seed_g(s0_r.c + s0_r.d);

    d2 = seed_g(s1_r.d + s1_r.c);
    c2 = s1_r.c + d2;
    s2_nxt.vld = s1_r.lane.vld;
    s2_nxt.dec = s1_r.lane.dec;
    s2_nxt.l = s1_r.lane.r;
    s2_nxt.r = s1_r.lane.l ^ {c2, d2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.lane.vld <= 1'b0;
      s1_r.lane.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign lane_o = s2_r;

endmodule

// ===== src/seed_block_cipher_128.sv =====
// seed block cipher top level: apb key registers, key schedule, round pipeline
// pipeline: 16 rounds of 3 register stages each lie between an accepted item and its result
// throughput: one item per cycle while the key schedule is idle; the whole pipeline holds while a result waits
// key derivation: runs after reset and after each key write, no item taken while it runs
// reset: key registers clear to zero and the zero-key round keys are derived
`include "seed_block_cipher_128_defines.svh"
module seed_block_cipher_128 (
  input  logic                        clk,
  input  logic                        rst_n,
  seed_in_if.sink                     in_ch,
  seed_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [seed_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]                 cfg_pwdata,
  output logic [63:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import seed_pkg::*;

  logic          wr, en, busy;
  logic [63:0]   key_high_r, key_high_nxt, key_low_r, key_low_nxt;
  seed_key_cmd_t cmd;
  seed_rk_tab_t  rk;
  seed_lane_t    lane [ROUNDS+1];

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt = key_low_r;
    if (wr && cfg_paddr[3] == REG_KEY_HIGH) begin
      key_high_nxt = cfg_pwdata;
    end
    if (wr && cfg_paddr[3] == REG_KEY_LOW) begin
      key_low_nxt = cfg_pwdata;
    end
    cmd.wr = wr;
    cmd.key_high = key_high_nxt;
    cmd.key_low = key_low_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r <= key_low_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_KEY_LOW) ? key_low_r : key_high_r;

  seed_key_sched u_key_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .busy  (busy),
    .rk    (rk)
  );

  assign en = !lane[ROUNDS].vld || out_ch.ready;
  assign in_ch.ready = en && !busy;

  always_comb begin
    lane[0].vld = in_ch.valid && in_ch.ready;
    lane[0].dec = in_ch.req_type;
    lane[0].l = in_ch.block_high;
    lane[0].r = in_ch.block_low;
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    seed_round u_round (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .lane_i (lane[i]),
      .rk_enc (rk[i]),
      .rk_dec (rk[ROUNDS-1-i]),
      .lane_o (lane[i+1])
    );
  end

  assign out_ch.valid = lane[ROUNDS].vld;
  assign out_ch.result_high = lane[ROUNDS].r;
  assign out_ch.result_low = lane[ROUNDS].l;

  `SEED_ASSERT_NEXT(a_write_starts_sched, wr, busy)
  `SEED_ASSERT_SAME(a_no_item_while_busy, busy, !in_ch.ready)
  `SEED_ASSERT_NEXT(a_stall_holds_result, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(out_ch.result_high) && $stable(out_ch.result_low))

endmodule
